### sv/tbuc_pkg.sv
// shared types and constants of the nine-way uniform square counter
package tbuc_pkg;

    // ternary value codes as used for counters and tallies
    localparam logic [1:0] VAL_MINUS = 2'd0;
    localparam logic [1:0] VAL_ZERO  = 2'd1;
    localparam logic [1:0] VAL_PLUS  = 2'd2;

    // raw two's complement cell codes
    localparam logic [1:0] CELL_ZERO = 2'b00;
    localparam logic [1:0] CELL_PLUS = 2'b01;

    // children per block and counter widths
    localparam logic [3:0] CHILDREN = 4'd9;
    localparam int CNT_W   = 4;
    localparam int INC_W   = 7;
    localparam int TALLY_W = 16;

    // partial summary of one block: child counts per value and mixed flag
    typedef struct packed {
        logic                       mixed;
        logic [2:0][CNT_W-1:0]      cnt;
    } t_sum;

    // control and tally increments that travel with one cell down the chain
    typedef struct packed {
        logic                       valid;
        logic                       active;
        logic                       uni;
        logic [1:0]                 val;
        logic [2:0][INC_W-1:0]      inc;
    } t_tok;

endpackage

### sv/ternary_block_uniform_count.sv
// path from input transfer to result: the entry stage, one stage per level up to MAX_ORDER,
// then the result register, whatever the grid order
// throughput: one cell per cycle while the chain is not stalled, one level cell of the chain per stage
// the chain stalls only when a result reaches the end while the previous one waits
// reset is synchronous: clears counts, position and grid order
// summary stores are not cleared; each block overwrites its entry on its first child
module ternary_block_uniform_count
    import tbuc_pkg::*;
#(
    parameter int MAX_ORDER = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [1:0]  i_cell_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_count_minus,
    output logic [15:0]        o_count_zero,
    output logic [15:0]        o_count_plus,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_grid_order
);

    localparam logic [2:0] MAX_ORD3 = 3'(MAX_ORDER);

    logic [2:0]                 r_grid_order;
    logic [2:0]                 ord;
    logic [2*MAX_ORDER-1:0]     r_row;
    logic [2*MAX_ORDER-1:0]     r_col;
    logic [2*MAX_ORDER-1:0]     n_row;
    logic [2*MAX_ORDER-1:0]     n_col;
    t_tok                       r_tok0;
    logic [2*MAX_ORDER-1:0]     r_row0;
    logic [2*MAX_ORDER-1:0]     r_col0;
    t_tok                       w_tok [MAX_ORDER+1];
    logic [2*MAX_ORDER-1:0]     w_row [MAX_ORDER+1];
    logic [2*MAX_ORDER-1:0]     w_col [MAX_ORDER+1];
    logic [2:0][TALLY_W-1:0]    r_tally;
    logic [2:0][TALLY_W-1:0]    n_tally;
    logic [2:0][TALLY_W-1:0]    r_out;
    logic                       r_out_valid;
    logic                       en;
    logic                       in_fire;
    logic                       cfg_fire;
    logic                       emit;
    logic [1:0]                 in_val;
    t_tok                       fin;

    assign ord      = (r_grid_order > MAX_ORD3) ? MAX_ORD3 : r_grid_order;
    assign fin      = w_tok[MAX_ORDER];
    assign emit     = fin.valid && fin.active;
    assign en       = !(r_out_valid && !i_out_ready && emit);
    assign in_fire  = i_in_valid && en;
    assign cfg_fire = i_cfg_valid;

    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // value code of the incoming cell
    always_comb begin
        unique case (i_cell_value)
            CELL_PLUS: in_val = VAL_PLUS;
            CELL_ZERO: in_val = VAL_ZERO;
            default:   in_val = VAL_MINUS;
        endcase
    end

    // base three position counters, column then row
    always_comb begin
        logic carry;
        n_col = r_col;
        n_row = r_row;
        carry = 1'b1;
        for (int d = 0; d < MAX_ORDER; d++) begin
            if (d < int'(ord) && carry) begin
                if (r_col[2*d+:2] == 2'd2) begin
                    n_col[2*d+:2] = 2'd0;
                end else begin
                    n_col[2*d+:2] = r_col[2*d+:2] + 2'd1;
                    carry = 1'b0;
                end
            end
        end
        for (int d = 0; d < MAX_ORDER; d++) begin
            if (d < int'(ord) && carry) begin
                if (r_row[2*d+:2] == 2'd2) begin
                    n_row[2*d+:2] = 2'd0;
                end else begin
                    n_row[2*d+:2] = r_row[2*d+:2] + 2'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    // config register and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_order <= '0;
            r_row        <= '0;
            r_col        <= '0;
        end else if (cfg_fire) begin
            r_grid_order <= i_grid_order;
            r_row        <= '0;
            r_col        <= '0;
        end else if (in_fire) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // entry stage of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.valid <= 1'b0;
        end else if (en) begin
            r_tok0.valid  <= in_fire;
            r_tok0.active <= 1'b1;
            r_tok0.uni    <= 1'b1;
            r_tok0.val    <= in_val;
            r_tok0.inc    <= '0;
            r_row0        <= r_row;
            r_col0        <= r_col;
        end
    end

    assign w_tok[0] = r_tok0;
    assign w_row[0] = r_row0;
    assign w_col[0] = r_col0;

    // one cell per level
    generate
        for (genvar L = 1; L <= MAX_ORDER; L++) begin : g_lvl
            tbuc_cell #(
                .MAX_ORDER (MAX_ORDER),
                .LEVEL     (L)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_en        (en),
                .i_order     (ord),
                .i_tok       (w_tok[L-1]),
                .i_row       (w_row[L-1]),
                .i_col       (w_col[L-1]),
                .i_ahead_col ((L == 1) ? r_col : w_col[(L >= 2) ? L-2 : 0]),
                .o_tok       (w_tok[L]),
                .o_row       (w_row[L]),
                .o_col       (w_col[L])
            );
        end
    endgenerate

    // saturating tally update with the whole grid counted on the last cell
    always_comb begin
        logic [TALLY_W:0]  sum;
        logic [INC_W-1:0]  add;
        for (int k = 0; k < 3; k++) begin
            add = fin.inc[k];
            if (emit && fin.uni && fin.val == 2'(k)) begin
                add = add + INC_W'(1);
            end
            sum = {1'b0, r_tally[k]} + (TALLY_W+1)'(add);
            n_tally[k] = sum[TALLY_W] ? {TALLY_W{1'b1}} : sum[TALLY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else if (cfg_fire) begin
            r_tally <= '0;
        end else if (en && fin.valid) begin
            r_tally <= emit ? '0 : n_tally;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && emit) begin
            r_out_valid <= 1'b1;
            r_out       <= n_tally;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_count_minus = r_out[VAL_MINUS];
    assign o_count_zero  = r_out[VAL_ZERO];
    assign o_count_plus  = r_out[VAL_PLUS];

`ifndef SYNTHESIS
    // input back-pressure only while a result waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("stall without waiting result");

    // a config write starts from empty tallies
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_tally == '0)
        else $error("tallies not cleared by config write");

    // a new result comes only from a finished grid at the end of the chain
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(fin.valid && fin.active))
        else $error("result without finished grid");
`endif

endmodule

### sv/tbuc_cell.sv
// one level of the chain: partial summaries of the blocks of that level
module tbuc_cell
    import tbuc_pkg::*;
#(
    parameter int MAX_ORDER = 5,
    parameter int LEVEL     = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [2:0]             i_order,
    input  t_tok                   i_tok,
    input  logic [2*MAX_ORDER-1:0] i_row,
    input  logic [2*MAX_ORDER-1:0] i_col,
    input  logic [2*MAX_ORDER-1:0] i_ahead_col,
    output t_tok                   o_tok,
    output logic [2*MAX_ORDER-1:0] o_row,
    output logic [2*MAX_ORDER-1:0] o_col
);

    localparam int AW    = (MAX_ORDER > LEVEL) ? 2 * (MAX_ORDER - LEVEL) : 1;
    localparam int DEPTH = 1 << AW;

    t_sum                   r_mem [DEPTH];
    t_sum                   r_rd;
    t_tok                   r_tok;
    t_tok                   n_tok;
    logic [2*MAX_ORDER-1:0] r_row;
    logic [2*MAX_ORDER-1:0] r_col;
    logic [AW-1:0]          w_addr;
    logic [AW-1:0]          rd_addr;
    t_sum                   w_sum;
    logic                   work;
    logic [1:0]             cr;
    logic [1:0]             cc;
    logic                   first;
    logic                   last;
    logic                   found;
    logic [1:0]             found_val;

    // block column address from the upper column digits
    generate
        if (MAX_ORDER > LEVEL) begin : g_addr
            assign w_addr  = i_col[2*MAX_ORDER-1:2*LEVEL];
            assign rd_addr = i_ahead_col[2*MAX_ORDER-1:2*LEVEL];
        end else begin : g_addr_one
            assign w_addr  = '0;
            assign rd_addr = '0;
        end
    endgenerate

    // child position within the block of this level
    assign cr    = i_row[2*(LEVEL-1)+:2];
    assign cc    = i_col[2*(LEVEL-1)+:2];
    assign first = (cr == 2'd0) && (cc == 2'd0);
    assign last  = (cr == 2'd2) && (cc == 2'd2);
    assign work  = i_tok.valid && i_tok.active && (int'(i_order) >= LEVEL);

    // fold the child into the summary and resolve a finished block
    always_comb begin
        w_sum = first ? '0 : r_rd;
        if (i_tok.uni) begin
            w_sum.cnt[i_tok.val] = w_sum.cnt[i_tok.val] + 4'd1;
        end else begin
            w_sum.mixed = 1'b1;
        end
        found     = 1'b0;
        found_val = VAL_MINUS;
        for (int k = 0; k < 3; k++) begin
            if (!w_sum.mixed && w_sum.cnt[k] == CHILDREN) begin
                found     = 1'b1;
                found_val = 2'(k);
            end
        end
        n_tok = i_tok;
        if (work) begin
            n_tok.active = last;
            if (last) begin
                if (found) begin
                    n_tok.uni = 1'b1;
                    n_tok.val = found_val;
                end else begin
                    n_tok.uni = 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        n_tok.inc[k] = i_tok.inc[k] + INC_W'(w_sum.cnt[k]);
                    end
                end
            end
        end
    end

    // summary store with read ahead and bypass of the write in flight
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (work) begin
                r_mem[w_addr] <= w_sum;
            end
            r_rd <= (work && (w_addr == rd_addr)) ? w_sum : r_mem[rd_addr];
        end
    end

    // hand the cell to the next level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
            r_row <= i_row;
            r_col <= i_col;
        end
    end

    assign o_tok = r_tok;
    assign o_row = r_row;
    assign o_col = r_col;

endmodule
